// ----- design/lcora_pkg.sv -----
// shared constants and register codes for the load cell filter
package lcora_pkg;

    localparam int SAMPLE_W          = 24;
    localparam int WEIGHT_W          = 32;
    localparam int REG_W             = 32;
    localparam int FRAC_BITS         = 24;
    localparam int DEF_HISTORY_DEPTH = 16;
    localparam int PADDR_W           = 3;
    localparam int REG_IDX_W         = 1;

    localparam logic [REG_W-1:0]    SCALE_RECIP_RESET = 32'h0100_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_MAX        = {1'b0, {(WEIGHT_W-1){1'b1}}};
    localparam logic [WEIGHT_W-1:0] WEIGHT_MIN        = {1'b1, {(WEIGHT_W-1){1'b0}}};

    localparam logic [REG_IDX_W-1:0] REG_ZERO_OFFSET = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE_RECIP = 1'b1;

endpackage

// ----- design/lcora_div.sv -----
// iterative restoring divider, signed dividend by unsigned divisor, truncating
module lcora_div #(
    parameter int DVD_W = 28,
    parameter int DVS_W = 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [DVD_W-1:0] i_dividend,
    input  logic        [DVS_W-1:0] i_divisor,
    output logic                    o_done,
    output logic signed [DVD_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;

    logic [DVS_W:0]    w_trial;
    logic [DVS_W:0]    w_sub;
    logic              w_ge;
    logic [DVS_W-1:0]  w_rem_nx;
    logic [DVD_W-1:0]  w_neg_dvd;

    assign w_trial   = {r_rem, r_quo[DVD_W-1]};
    assign w_sub     = w_trial - {1'b0, r_dvs};
    assign w_ge      = (w_trial >= {1'b0, r_dvs});
    assign w_rem_nx  = w_ge ? w_sub[DVS_W-1:0] : w_trial[DVS_W-1:0];
    assign w_neg_dvd = -i_dividend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient bits shift in as dividend magnitude bits shift out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DVD_W-1];
            r_quo <= i_dividend[DVD_W-1] ? w_neg_dvd : i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_rem_nx;
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -signed'(r_quo) : signed'(r_quo);

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) && !i_start |-> r_done)
        else $error("divider finished without done");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while still busy");
`endif

endmodule

// ----- design/load_cell_outlier_reject_average_unit.sv -----
// load cell filter: outlier-rejecting moving average, scaling and offset
// Usage:
//   input channel i_in_valid/o_in_ready carries one raw 24-bit converter word
//   with calibrating and restart flags; output channel o_out_valid/i_out_ready
//   returns one signed 32-bit weight per request, in order.
//   Registers on the APB port: 0x0 zero_offset, 0x4 scale_reciprocal (Q8.24).
// Sequencing:
//   the history sits in a single-port memory with a registered read; the
//   sequencer sweeps it twice (sum, then deviation search) and runs two
//   divisions on a shared serial divider; the first sample after a clear
//   skips the filter.
//   One request is in flight at a time; the next is taken once the current
//   result sits in the output register.
// Reset: synchronous, active low; history fill count, write slot and
//   registers are cleared, scale_reciprocal returns to 1.0.
// Stall: a result held by i_out_ready low stays in the output register; the
//   next request is processed and then waits until that slot frees up.
module load_cell_outlier_reject_average_unit #(
    parameter int HISTORY_DEPTH = lcora_pkg::DEF_HISTORY_DEPTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic        [lcora_pkg::SAMPLE_W-1:0]  i_raw_sample,
    input  logic                                   i_calibrating,
    input  logic                                   i_restart,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [lcora_pkg::WEIGHT_W-1:0]  o_weight,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic        [lcora_pkg::PADDR_W-1:0]   paddr,
    input  logic        [lcora_pkg::REG_W-1:0]     pwdata,
    output logic        [lcora_pkg::REG_W-1:0]     prdata,
    output logic                                   pready
);

    import lcora_pkg::*;

    localparam int IDX_W  = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(HISTORY_DEPTH);
    localparam int PROD_W = SAMPLE_W + REG_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_DEV  = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_SCL  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]                 r_state;
    logic [2:0]                 n_state;
    logic [CNT_W-1:0]           r_fill;
    logic [IDX_W-1:0]           r_slot;
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           r_issue;
    logic                       r_dv;
    logic                       r_calib;
    logic signed [SAMPLE_W-1:0] r_val;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0]        r_wdev;
    logic [SAMPLE_W-1:0]        r_wval;
    logic [SAMPLE_W-1:0]        r_rd_data;
    logic [WEIGHT_W-1:0]        r_prod;
    logic                       r_neg;
    logic signed [WEIGHT_W-1:0] r_scaled;
    logic                       r_out_vld;
    logic signed [WEIGHT_W-1:0] r_weight;
    logic signed [REG_W-1:0]    r_zero_offset;
    logic [REG_W-1:0]           r_scale_recip;
    logic [SAMPLE_W-1:0]        r_hist [HISTORY_DEPTH];

    logic                       w_accept;
    logic [CNT_W-1:0]           w_fill_eff;
    logic [IDX_W-1:0]           w_slot_eff;
    logic [CNT_W-1:0]           w_count;
    logic [IDX_W-1:0]           w_slot_nx;
    logic                       w_pass;
    logic                       w_issue;
    logic                       w_pass_done;
    logic signed [SUM_W-1:0]    w_rd_ext;
    logic signed [SUM_W-1:0]    w_wval_ext;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [SAMPLE_W:0]   w_ndiff;
    logic [SAMPLE_W-1:0]        w_adev;
    logic                       w_div_start;
    logic signed [SUM_W-1:0]    w_div_dividend;
    logic [CNT_W-1:0]           w_div_divisor;
    logic                       w_div_done;
    logic signed [SUM_W-1:0]    w_div_quo;
    logic [SAMPLE_W-1:0]        w_mag;
    logic [PROD_W-1:0]          w_prod;
    logic [WEIGHT_W-1:0]        w_scaled;
    logic signed [WEIGHT_W:0]   w_off_diff;
    logic [WEIGHT_W-1:0]        w_off_sat;
    logic                       w_out_free;
    logic                       w_cfg_wr;
    logic [REG_IDX_W-1:0]       w_reg_idx;

    // request side
    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_fill_eff = i_restart ? '0 : r_fill;
    assign w_slot_eff = i_restart ? '0 : r_slot;
    assign w_count    = (w_fill_eff < CNT_W'(HISTORY_DEPTH)) ? w_fill_eff + CNT_W'(1)
                                                            : CNT_W'(HISTORY_DEPTH);
    assign w_slot_nx  = (w_slot_eff == IDX_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : w_slot_eff + IDX_W'(1);

    // memory sweep over entries 0 .. count-1, read data registered and arriving in the cycle after its address
    assign w_pass      = (r_state == ST_SUM) || (r_state == ST_DEV);
    assign w_issue     = w_pass && (r_issue != r_count);
    assign w_pass_done = w_pass && (r_issue == r_count) && !r_dv;

    assign w_rd_ext   = signed'({{(SUM_W-SAMPLE_W){r_rd_data[SAMPLE_W-1]}}, r_rd_data});
    assign w_wval_ext = signed'({{(SUM_W-SAMPLE_W){r_wval[SAMPLE_W-1]}}, r_wval});
    assign w_diff     = signed'({r_mean[SAMPLE_W-1], r_mean})
                      - signed'({r_rd_data[SAMPLE_W-1], r_rd_data});
    assign w_ndiff    = -w_diff;
    assign w_adev     = w_diff[SAMPLE_W] ? w_ndiff[SAMPLE_W-1:0] : w_diff[SAMPLE_W-1:0];

    // sum minus the dropped entry gives the second average's numerator
    assign w_div_start    = w_pass_done;
    assign w_div_dividend = (r_state == ST_SUM) ? r_sum : r_sum - w_wval_ext;
    assign w_div_divisor  = (r_state == ST_SUM) ? r_count : r_count - CNT_W'(1);

    lcora_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // scaling and offset
    assign w_mag      = r_val[SAMPLE_W-1] ? SAMPLE_W'(-r_val) : r_val;
    assign w_prod     = w_mag * r_scale_recip;
    assign w_scaled   = (!r_neg && r_prod[WEIGHT_W-1]) ? WEIGHT_MAX
                      : (r_neg ? -r_prod : r_prod);
    assign w_off_diff = signed'({r_scaled[WEIGHT_W-1], r_scaled})
                      - signed'({r_zero_offset[REG_W-1], r_zero_offset});
    assign w_off_sat  = (w_off_diff[WEIGHT_W] != w_off_diff[WEIGHT_W-1])
                      ? (w_off_diff[WEIGHT_W] ? WEIGHT_MIN : WEIGHT_MAX)
                      : w_off_diff[WEIGHT_W-1:0];
    assign w_out_free = !r_out_vld || i_out_ready;

    // configuration port
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[PADDR_W-1 -: REG_IDX_W];
    assign pready    = 1'b1;

    always_comb begin
        unique case (w_reg_idx)
            REG_ZERO_OFFSET: prdata = r_zero_offset;
            REG_SCALE_RECIP: prdata = r_scale_recip;
            default:         prdata = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (w_fill_eff == '0) ? ST_MUL : ST_SUM;
                end
            end
            ST_SUM: begin
                if (w_pass_done) begin
                    n_state = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (w_div_done) begin
                    n_state = ST_DEV;
                end
            end
            ST_DEV: begin
                if (w_pass_done) begin
                    n_state = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (w_div_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: n_state = ST_SCL;
            ST_SCL: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // history memory: writes only at request time, reads only during sweeps,
    // so the sequencer keeps the two from touching the same entry at once
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hist[w_slot_eff] <= i_raw_sample;
        end
        if (w_issue) begin
            r_rd_data <= r_hist[r_issue[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_fill        <= '0;
            r_slot        <= '0;
            r_issue       <= '0;
            r_dv          <= 1'b0;
            r_out_vld     <= 1'b0;
            r_zero_offset <= '0;
            r_scale_recip <= SCALE_RECIP_RESET;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) begin
                unique case (w_reg_idx)
                    REG_ZERO_OFFSET: r_zero_offset <= pwdata;
                    REG_SCALE_RECIP: r_scale_recip <= pwdata;
                    default: ;
                endcase
            end
            if (w_accept) begin
                r_fill <= w_count;
                r_slot <= w_slot_nx;
            end
            r_dv <= w_issue;
            if (w_issue) begin
                r_issue <= r_issue + CNT_W'(1);
            end else if (w_pass_done) begin
                r_issue <= '0;
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_calib <= i_calibrating;
            r_val   <= i_raw_sample;
            r_count <= w_count;
            r_sum   <= '0;
        end
        if ((r_state == ST_SUM) && r_dv) begin
            r_sum <= r_sum + w_rd_ext;
        end
        if ((r_state == ST_DIV1) && w_div_done) begin
            r_mean <= w_div_quo[SAMPLE_W-1:0];
            r_wdev <= '0;
        end
        // last index wins on equal deviation
        if ((r_state == ST_DEV) && r_dv && (w_adev >= r_wdev)) begin
            r_wdev <= w_adev;
            r_wval <= r_rd_data;
        end
        if ((r_state == ST_DIV2) && w_div_done) begin
            r_val <= w_div_quo[SAMPLE_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_neg  <= r_val[SAMPLE_W-1];
            r_prod <= w_prod[FRAC_BITS +: WEIGHT_W];
        end
        if (r_state == ST_SCL) begin
            r_scaled <= w_scaled;
        end
        if ((r_state == ST_OUT) && w_out_free) begin
            r_weight <= r_calib ? r_scaled : signed'(w_off_sat);
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_weight    = r_weight;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");
    a_restart_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_restart |=> (r_fill == CNT_W'(1)) && (r_slot == IDX_W'(1 % HISTORY_DEPTH)))
        else $error("restart did not clear history state");
    a_first_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (i_restart || (r_fill == '0)) |=> (r_state == ST_MUL))
        else $error("first sample after clear went through the filter");
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && r_out_vld && !i_out_ready |=>
            (r_state == ST_OUT) && $stable(r_weight))
        else $error("pending result overwritten");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_count != '0))
        else $error("busy with empty history");
`endif

endmodule

// ----- verif/load_cell_outlier_reject_average_unit_tb.sv -----
// self-checking testbench for the load cell outlier-rejecting average unit
`timescale 1ns / 1ps

module load_cell_outlier_reject_average_unit_tb;
    import lcora_pkg::*;

    localparam int DEPTH = DEF_HISTORY_DEPTH;

    typedef struct packed {
        logic [SAMPLE_W-1:0] raw;
        logic                cal;
        logic                restart;
    } sample_req_t;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       i_in_valid    = 1'b0;
    logic                       o_in_ready;
    logic        [SAMPLE_W-1:0] i_raw_sample  = '0;
    logic                       i_calibrating = 1'b0;
    logic                       i_restart     = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready   = 1'b0;
    logic signed [WEIGHT_W-1:0] o_weight;
    logic                       psel          = 1'b0;
    logic                       penable       = 1'b0;
    logic                       pwrite        = 1'b0;
    logic        [PADDR_W-1:0]  paddr         = '0;
    logic        [REG_W-1:0]    pwdata        = '0;
    logic        [REG_W-1:0]    prdata;
    logic                       pready;

    load_cell_outlier_reject_average_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_raw_sample  (i_raw_sample),
        .i_calibrating (i_calibrating),
        .i_restart     (i_restart),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_weight      (o_weight),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state and register copies
    longint                     hist [DEPTH];
    int                         wr_slot;
    int                         filled;
    logic signed [REG_W-1:0]    offset_reg = '0;
    logic        [REG_W-1:0]    recip_q824 = SCALE_RECIP_RESET;

    sample_req_t                pending_requests [$];
    logic        [WEIGHT_W-1:0] expected_weights [$];
    int                         issued_count   = 0;
    int                         accepted_count = 0;
    int                         mismatch_count = 0;
    bit                         calm           = 1'b0;
    int                         in_gap         = 0;
    int                         out_stall      = 0;

    function automatic longint sat32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // updates the history copy and returns the weight this request produces
    function automatic logic [WEIGHT_W-1:0] predict_weight(input logic [SAMPLE_W-1:0] raw,
                                                           input logic cal,
                                                           input logic rst);
        longint smp, sum, mean, dev, worst_dev, filt, mag, prod, res;
        int     cnt, worst, i;
        bit     first;
        smp = longint'($signed(raw));
        if (rst) begin
            foreach (hist[k]) hist[k] = 0;
            wr_slot = 0;
            filled  = 0;
        end
        first         = (filled == 0);
        hist[wr_slot] = smp;
        worst         = wr_slot;
        wr_slot       = (wr_slot + 1 >= DEPTH) ? 0 : wr_slot + 1;
        cnt           = (filled + 1 < DEPTH) ? filled + 1 : DEPTH;
        if (filled < DEPTH)
            filled++;
        if (first) begin
            filt = smp;
        end else begin
            sum = 0;
            for (i = 0; i < cnt; i++) sum += hist[i];
            mean = sum / cnt;
            // farthest entry from the mean, last one wins a tie
            worst_dev = 0;
            for (i = 0; i < cnt; i++) begin
                dev = mean - hist[i];
                if (dev < 0)
                    dev = -dev;
                if (dev >= worst_dev) begin
                    worst     = i;
                    worst_dev = dev;
                end
            end
            sum = 0;
            for (i = 0; i < cnt; i++)
                if (i != worst)
                    sum += hist[i];
            filt = sum / (cnt - 1);
        end
        mag  = (filt < 0) ? -filt : filt;
        prod = (mag * longint'(recip_q824)) >> FRAC_BITS;
        if (prod > 64'sd2147483648)
            prod = 64'sd2147483648;
        res = sat32((filt < 0) ? -prod : prod);
        if (!cal)
            res = sat32(res - longint'(offset_reg));
        return res[WEIGHT_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [WEIGHT_W-1:0] got,
                                   input logic [WEIGHT_W-1:0] want);
        $display("mismatch: %s: got %0d (0x%08h) expected %0d (0x%08h)",
                 what, $signed(got), got, $signed(want), want);
        mismatch_count++;
    endtask

    task automatic queue_request(input logic [SAMPLE_W-1:0] raw, input logic cal,
                                 input logic rst);
        pending_requests.push_back('{raw: raw, cal: cal, restart: rst});
        issued_count++;
    endtask

    task automatic queue_random_request(input logic [SAMPLE_W-1:0] base);
        logic [SAMPLE_W-1:0] raw;
        case ($urandom_range(0, 9))
            0: raw = SAMPLE_W'($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0: raw = 24'h000000;
                    1: raw = 24'h7FFFFF;
                    2: raw = 24'h800000;
                    default: raw = 24'hFFFFFF;
                endcase
            end
            // occasional spike well away from the running level
            2: raw = base + SAMPLE_W'($urandom_range(0, 24'h0FFFFF)) - 24'h080000;
            default: raw = base + SAMPLE_W'($urandom_range(0, 255)) - 24'd128;
        endcase
        queue_request(raw, $urandom_range(0, 3) == 0, $urandom_range(0, 39) == 0);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ZERO_OFFSET: offset_reg = val;
            REG_SCALE_RECIP: recip_q824 = val;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (!(accepted_count == issued_count && expected_weights.size() == 0))
            @(posedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        sample_req_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_weights.push_back(predict_weight(i_raw_sample, i_calibrating,
                                                          i_restart));
                accepted_count++;
                in_gap = calm ? 0 : $urandom_range(0, 8);
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the request until taken
            end else if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                nxt = pending_requests.pop_front();
                i_raw_sample  <= nxt.raw;
                i_calibrating <= nxt.cal;
                i_restart     <= nxt.restart;
                i_in_valid    <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        logic [WEIGHT_W-1:0] want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            out_stall = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_weights.size() == 0) begin
                    report_mismatch("weight with no request pending", o_weight, '0);
                end else begin
                    want = expected_weights.pop_front();
                    if (o_weight !== want)
                        report_mismatch("weight", o_weight, want);
                end
                out_stall = calm ? 0 : $urandom_range(0, 8);
            end
            if (out_stall > 0) begin
                out_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] base;
        logic [REG_W-1:0]    off_val, recip_val;
        foreach (hist[k]) hist[k] = 0;
        wr_slot = 0;
        filled  = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, both flags, ties and a spike at reset defaults
        queue_request(24'h000000, 1'b0, 1'b1);
        queue_request(24'h7FFFFF, 1'b0, 1'b0);
        queue_request(24'h800000, 1'b0, 1'b0);
        queue_request(24'hFFFFFF, 1'b1, 1'b0);
        queue_request(24'h000001, 1'b1, 1'b0);
        queue_request(24'd100,    1'b0, 1'b1);
        queue_request(24'd200,    1'b0, 1'b0);
        queue_request(24'd300,    1'b1, 1'b0);
        queue_request(24'd200,    1'b0, 1'b0);
        queue_request(24'h7FFFFF, 1'b0, 1'b0);
        queue_request(24'd50,     1'b0, 1'b0);
        queue_request(24'h800000, 1'b1, 1'b1);
        queue_request(24'h800000, 1'b0, 1'b0);
        queue_request(24'h7FFFFF, 1'b0, 1'b0);
        queue_request(24'h555555, 1'b0, 1'b1);
        queue_request(24'hAAAAAA, 1'b1, 1'b0);
        wait_idle();

        for (int phase = 0; phase < 12; phase++) begin
            case (phase)
                0: begin off_val = 32'd0;        recip_val = SCALE_RECIP_RESET; end
                1: begin off_val = WEIGHT_MAX;   recip_val = 32'hFFFF_FFFF; end
                2: begin off_val = WEIGHT_MIN;   recip_val = 32'h0000_0001; end
                3: begin off_val = WEIGHT_MIN;   recip_val = 32'hFFFF_FFFF; end
                4: begin off_val = WEIGHT_MAX;   recip_val = 32'h0000_0001; end
                default: begin
                    off_val   = $urandom;
                    recip_val = ($urandom_range(0, 1) == 0) ?
                                $urandom_range(32'h0080_0000, 32'h0400_0000) : $urandom;
                    if (recip_val == 0)
                        recip_val = 32'h0000_0001;
                end
            endcase
            if (phase > 0) begin
                write_reg(REG_ZERO_OFFSET, off_val);
                write_reg(REG_SCALE_RECIP, recip_val);
            end
            calm = ($urandom_range(0, 2) == 0);
            base = SAMPLE_W'($urandom);
            for (int n = 0; n < 110; n++)
                queue_random_request(base);
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("load_cell_outlier_reject_average_unit verification clean");
        else
            $display("load_cell_outlier_reject_average_unit verification failed");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("load_cell_outlier_reject_average_unit verification failed");
        $finish;
    end

endmodule

// ----- load_cell_outlier_reject_average_unit.f -----
design/lcora_pkg.sv
design/lcora_div.sv
design/load_cell_outlier_reject_average_unit.sv
verif/load_cell_outlier_reject_average_unit_tb.sv
